// ----- sv/lcfr_pkg.sv -----
`timescale 1ns / 1ps

package lcfr_pkg;

   localparam int unsigned HEADER_BYTES = 4;
   localparam int unsigned COUNT_WIDTH  = 17;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [7:0]  ACK_BAD      = 8'h30;
   localparam logic [7:0]  ACK_GOOD     = 8'h31;
   localparam logic [7:0]  ACK_NEWLINE  = 8'h0A;

   // Positions of the header bytes within a frame.
   localparam logic [COUNT_WIDTH-1:0] POS_LEN_LO = 17'd0;
   localparam logic [COUNT_WIDTH-1:0] POS_LEN_HI = 17'd1;
   localparam logic [COUNT_WIDTH-1:0] POS_CRC_LO = 17'd2;
   localparam logic [COUNT_WIDTH-1:0] POS_CRC_HI = 17'd3;

   // One finished frame, as passed from the front end to the result side.
   typedef struct packed {
      logic push;
      logic ok;
   } event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // CRC-16/MCRF4XX update over one byte, reflected polynomial 0x8408.
   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

endpackage

// ----- sv/lcfr_front.sv -----
`timescale 1ns / 1ps

module lcfr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   output lcfr_pkg::event_type   event_out
);

   logic [lcfr_pkg::COUNT_WIDTH-1:0] byte_count_ff, byte_count_in, count_next;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [15:0] frame_crc_ff, frame_crc_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic        frame_done;

   always_comb begin
      frame_length_in = frame_length_ff;
      frame_crc_in    = frame_crc_ff;
      running_crc_in  = running_crc_ff;
      unique case (byte_count_ff)
         lcfr_pkg::POS_LEN_LO: frame_length_in = {8'h00, rx_byte};
         lcfr_pkg::POS_LEN_HI: frame_length_in = {rx_byte, frame_length_ff[7:0]};
         lcfr_pkg::POS_CRC_LO: frame_crc_in    = {8'h00, rx_byte};
         lcfr_pkg::POS_CRC_HI: frame_crc_in    = {rx_byte, frame_crc_ff[7:0]};
         default:              running_crc_in  = lcfr_pkg::crc_add_byte(running_crc_ff, rx_byte);
      endcase
      count_next = byte_count_ff + 17'd1;
      frame_done = (count_next == ({1'b0, frame_length_in} +
                    lcfr_pkg::COUNT_WIDTH'(lcfr_pkg::HEADER_BYTES)));
      byte_count_in = count_next;
      if (frame_done) begin
         byte_count_in  = '0;
         running_crc_in = lcfr_pkg::CRC_INIT;
      end
      event_out.push = accept && frame_done;
      if (byte_count_ff >= lcfr_pkg::COUNT_WIDTH'(lcfr_pkg::HEADER_BYTES)) begin
         event_out.ok = lcfr_pkg::crc_add_byte(running_crc_ff, rx_byte) == frame_crc_in;
      end else begin
         event_out.ok = running_crc_ff == frame_crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         frame_length_ff <= '0;
         frame_crc_ff    <= '0;
         running_crc_ff  <= lcfr_pkg::CRC_INIT;
      end else if (accept) begin
         byte_count_ff   <= byte_count_in;
         frame_length_ff <= frame_length_in;
         frame_crc_ff    <= frame_crc_in;
         running_crc_ff  <= running_crc_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= 17'd65539)
      else $error("frame byte count out of range");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      event_out.push |=> (byte_count_ff == '0) && (running_crc_ff == lcfr_pkg::CRC_INIT))
      else $error("frame did not restart after acknowledgement");
`endif

endmodule

// ----- sv/lcfr_event_fifo.sv -----
`timescale 1ns / 1ps

module lcfr_event_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lcfr_pkg::event_type          event_in,
   input  logic                         pop,
   output logic                         ok_out,
   output lcfr_pkg::queue_status_type   status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic             ok_mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = event_in.push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign ok_out       = ok_mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ok_mem[wr_ptr_ff] <= event_in.ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_step(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_step(rd_ptr_ff);
         end
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      event_in.push |-> !status.full)
      else $error("event pushed into a full queue");
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("event queue count out of range");
`endif

endmodule

// ----- sv/lcfr_back.sv -----
`timescale 1ns / 1ps

module lcfr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  lcfr_pkg::queue_status_type   queue_status,
   input  logic                         queue_ok,
   output logic                         queue_pop,
   input  logic                         pop,
   output logic                         empty,
   output logic [7:0]                   ack_byte,
   output logic                         ack_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIGIT,
      ST_NEWLINE
   } state_type;

   state_type state_ff;
   logic      ok_ff;
   logic      slot_free;

   assign slot_free = (state_ff == ST_IDLE) || ((state_ff == ST_NEWLINE) && pop);
   assign queue_pop = slot_free && !queue_status.empty;
   assign empty     = state_ff == ST_IDLE;
   assign ack_last  = state_ff == ST_NEWLINE;
   assign ack_byte  = (state_ff == ST_NEWLINE) ? lcfr_pkg::ACK_NEWLINE :
                      (ok_ff ? lcfr_pkg::ACK_GOOD : lcfr_pkg::ACK_BAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ok_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (queue_pop) begin
                  state_ff <= ST_DIGIT;
                  ok_ff    <= queue_ok;
               end
            end
            ST_DIGIT: begin
               if (pop) begin
                  state_ff <= ST_NEWLINE;
               end
            end
            ST_NEWLINE: begin
               if (queue_pop) begin
                  state_ff <= ST_DIGIT;
                  ok_ff    <= queue_ok;
               end else if (pop) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_digit_then_newline: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) && pop |=> (state_ff == ST_NEWLINE))
      else $error("acknowledgement digit not followed by newline");
   a_digit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) && !pop |=> (state_ff == ST_DIGIT) && $stable(ok_ff))
      else $error("stalled acknowledgement digit changed");
`endif

endmodule

// ----- sv/length_crc_frame_receiver_unit.sv -----
`timescale 1ns / 1ps

// Receives a byte stream of frames, each a 16-bit little-endian payload length, a 16-bit
// little-endian CRC-16/MCRF4XX and the payload, and answers every frame with '1' (CRC good)
// or '0' (CRC bad) followed by a newline flagged by rsp_ack_last. One byte is taken per
// cycle while full is low; the header capture and the byte-wide CRC update finish in the
// cycle of the transfer. Finished frames wait in an EVENT_DEPTH-entry queue, and the result
// side sends two bytes per frame, one per cycle while pop is high. A frame is never shorter
// than four bytes, so full rises only when that queue fills because pop has been held low.
module length_crc_frame_receiver_unit #(
   parameter int unsigned EVENT_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_rx_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_ack_byte,
   output logic       rsp_ack_last
);

   lcfr_pkg::event_type        frame_event;
   lcfr_pkg::queue_status_type queue_status;
   logic                       queue_ok;
   logic                       queue_pop;
   logic                       accept;

   assign full   = queue_status.full;
   assign accept = push && !queue_status.full;

   lcfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .event_out (frame_event)
   );

   lcfr_event_fifo #(
      .DEPTH (EVENT_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .event_in (frame_event),
      .pop      (queue_pop),
      .ok_out   (queue_ok),
      .status   (queue_status)
   );

   lcfr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .queue_ok     (queue_ok),
      .queue_pop    (queue_pop),
      .pop          (pop),
      .empty        (empty),
      .ack_byte     (rsp_ack_byte),
      .ack_last     (rsp_ack_last)
   );

endmodule

// ----- sim/length_crc_frame_receiver_unit_tb.sv -----
`timescale 1ns / 1ps

module length_crc_frame_receiver_unit_tb;

   localparam int unsigned ITEM_TARGET    = 1350;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES  = 20;

   typedef struct {
      logic [7:0] ack_byte;
      logic       ack_last;
   } ack_entry_type;

   class ack_scoreboard_type;
      logic [lcfr_pkg::COUNT_WIDTH-1:0] byte_count;
      logic [15:0]                      frame_length;
      logic [15:0]                      frame_crc;
      logic [15:0]                      running_crc;
      ack_entry_type                    pending[$];
      int unsigned                      mismatches;

      function new();
         byte_count   = '0;
         frame_length = '0;
         frame_crc    = '0;
         running_crc  = lcfr_pkg::CRC_INIT;
         mismatches   = 0;
      endfunction

      static function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] value);
         logic [15:0] c;
         c = crc ^ {8'h00, value};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
         end
         return c;
      endfunction

      function void report_mismatch(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endfunction

      // Called for every input transfer; queues the acknowledgement when a frame ends.
      function void note_byte(input logic [7:0] value);
         ack_entry_type entry;
         case (byte_count)
            lcfr_pkg::POS_LEN_LO: frame_length = {8'h00, value};
            lcfr_pkg::POS_LEN_HI: frame_length = {value, frame_length[7:0]};
            lcfr_pkg::POS_CRC_LO: frame_crc = {8'h00, value};
            lcfr_pkg::POS_CRC_HI: frame_crc = {value, frame_crc[7:0]};
            default: running_crc = crc_step(running_crc, value);
         endcase
         byte_count = byte_count + 1'b1;
         if (byte_count >= lcfr_pkg::HEADER_BYTES &&
             (byte_count - lcfr_pkg::HEADER_BYTES) == frame_length) begin
            entry.ack_byte = (running_crc == frame_crc) ? lcfr_pkg::ACK_GOOD : lcfr_pkg::ACK_BAD;
            entry.ack_last = 1'b0;
            pending.push_back(entry);
            entry.ack_byte = lcfr_pkg::ACK_NEWLINE;
            entry.ack_last = 1'b1;
            pending.push_back(entry);
            byte_count  = '0;
            running_crc = lcfr_pkg::CRC_INIT;
         end
      endfunction

      function void check_ack(input logic [7:0] ack_byte, input logic ack_last);
         ack_entry_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h last %b", ack_byte, ack_last));
         end else begin
            want = pending.pop_front();
            if (ack_byte !== want.ack_byte) begin
               report_mismatch($sformatf("ack_byte %02h, expected %02h", ack_byte, want.ack_byte));
            end
            if (ack_last !== want.ack_last) begin
               report_mismatch($sformatf("ack_last %b, expected %b", ack_last, want.ack_last));
            end
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_rx_byte;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_ack_byte;
   logic       rsp_ack_last;

   ack_scoreboard_type sb;
   int unsigned        send_idle_pct;
   int unsigned        pop_stall_pct;
   int unsigned        sent_items;
   int unsigned        quiet_cycles;

   length_crc_frame_receiver_unit dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_rx_byte  (req_rx_byte),
      .empty        (empty),
      .pop          (pop),
      .rsp_ack_byte (rsp_ack_byte),
      .rsp_ack_last (rsp_ack_last)
   );

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 99) >= pop_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            sb.check_ack(rsp_ack_byte, rsp_ack_last);
         end
         if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[length_crc_frame_receiver_unit] ERROR");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (full);
      sb.note_byte(value);
      sent_items++;
   endtask

   // A negative fill value gives a random payload.
   task automatic send_frame(input int len, input bit crc_good, input int fill);
      logic [7:0]  payload[$];
      logic [15:0] crc;
      logic [15:0] crc_field;
      logic [7:0]  value;
      crc = lcfr_pkg::CRC_INIT;
      for (int i = 0; i < len; i++) begin
         value = (fill < 0) ? 8'($urandom) : fill[7:0];
         payload.push_back(value);
         crc = ack_scoreboard_type::crc_step(crc, value);
      end
      crc_field = crc;
      if (!crc_good) begin
         if ($urandom_range(0, 1) == 1) begin
            crc_field = crc ^ (16'h0001 << $urandom_range(0, 15));
         end else begin
            crc_field = crc ^ 16'($urandom_range(1, 65535));
         end
      end
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      send_byte(crc_field[7:0]);
      send_byte(crc_field[15:8]);
      foreach (payload[i]) begin
         send_byte(payload[i]);
      end
   endtask

   // Random bytes that break frame alignment, then enough bytes to close the frame.
   // The length high byte is kept small so that the frame ends soon.
   task automatic send_noise(input int count);
      logic [7:0] value;
      for (int i = 0; i < count; i++) begin
         value = (sb.byte_count == lcfr_pkg::POS_LEN_HI) ? 8'($urandom_range(0, 1))
                                                         : 8'($urandom);
         send_byte(value);
      end
      while (sb.byte_count != lcfr_pkg::POS_LEN_LO) begin
         value = (sb.byte_count == lcfr_pkg::POS_LEN_HI) ? 8'($urandom_range(0, 1))
                                                         : 8'($urandom);
         send_byte(value);
      end
   endtask

   task automatic wait_for_acks;
      @(negedge clock);
      push <= 1'b0;
      while (sb.pending.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int unsigned idle_by_phase[4];
      int unsigned stall_by_phase[4];
      int unsigned choice;
      int          len;
      idle_by_phase  = '{0, 87, 0, 14};
      stall_by_phase = '{0, 0, 87, 14};
      sb             = new();
      reset          = 1'b1;
      push           = 1'b0;
      pop            = 1'b0;
      req_rx_byte    = 8'h00;
      send_idle_pct  = 0;
      pop_stall_pct  = 0;
      sent_items     = 0;
      quiet_cycles   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_frame(0, 1'b1, -1);
      send_frame(0, 1'b0, -1);
      send_frame(1, 1'b1, 8'h00);
      send_frame(1, 1'b0, 8'hFF);
      send_frame(2, 1'b1, 8'hFF);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_by_phase[phase];
         pop_stall_pct = stall_by_phase[phase];
         while (sent_items < (phase + 1) * ITEM_TARGET / 4) begin
            choice = $urandom_range(0, 99);
            if (choice < 12) begin
               send_noise($urandom_range(1, 8));
            end else begin
               if (choice == 12) begin
                  len = $urandom_range(256, 400);
               end else if ($urandom_range(0, 3) == 0) begin
                  len = 0;
               end else begin
                  len = $urandom_range(1, 24);
               end
               send_frame(len, 1'($urandom_range(0, 1)), -1);
            end
         end
         wait_for_acks();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending.size() != 0) begin
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
      end
      if (sb.mismatches == 0) begin
         $display("[length_crc_frame_receiver_unit] OK");
      end else begin
         $display("[length_crc_frame_receiver_unit] ERROR");
      end
      $finish;
   end

endmodule
